// ----- design/pr23_pkg.sv -----
// ----------------------------------------------------------------------------
// pr23_pkg - shared types and constants for the 2/3 polyphase resampler
// Holds the filter geometry, arithmetic widths, the coefficient ROM and the
// phase/skip step functions used by the sequencer and the MAC unit.
// ----------------------------------------------------------------------------
package pr23_pkg;

    // Rate change and filter geometry
    localparam int UP_FACTOR      = 2;
    localparam int DOWN_FACTOR    = 3;
    localparam int TAPS_PER_PHASE = 16;
    localparam int COEF_WIDTH     = 18;
    localparam int COEF_FRAC      = COEF_WIDTH - 2;

    // Derived widths
    localparam int SAMPLE_W  = 16;
    localparam int TAP_W     = $clog2(TAPS_PER_PHASE);
    localparam int PHASE_W   = 1;
    localparam int WAIT_W    = 2;
    localparam int ROM_AW    = PHASE_W + TAP_W;
    localparam int PROD_W    = COEF_WIDTH + SAMPLE_W;
    localparam int ACC_W     = PROD_W + TAP_W;
    localparam int STEP_W    = 5;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    // Control from the sequencer to the shared MAC
    typedef struct packed {
        logic start;   // clear the accumulator
        logic issue;   // multiply the presented tap this cycle
    } mac_ctrl_t;

    // Coefficient ROM, Q2.16; entry phase*TAPS_PER_PHASE + tap
    function automatic logic signed [COEF_WIDTH-1:0] coef_rom(
        input logic [ROM_AW-1:0] idx
    );
        logic signed [COEF_WIDTH-1:0] c;
        case (idx)
            5'd0:    c = -18'sd3;
            5'd1:    c = 18'sd183;
            5'd2:    c = -18'sd332;
            5'd3:    c = -18'sd780;
            5'd4:    c = 18'sd3055;
            5'd5:    c = -18'sd2792;
            5'd6:    c = -18'sd5286;
            5'd7:    c = 18'sd27227;
            5'd8:    c = 18'sd41639;
            5'd9:    c = 18'sd7855;
            5'd10:   c = -18'sd7580;
            5'd11:   c = 18'sd2071;
            5'd12:   c = 18'sd1107;
            5'd13:   c = -18'sd1051;
            5'd14:   c = 18'sd189;
            5'd15:   c = 18'sd31;
            5'd16:   c = 18'sd31;
            5'd17:   c = 18'sd189;
            5'd18:   c = -18'sd1051;
            5'd19:   c = 18'sd1107;
            5'd20:   c = 18'sd2071;
            5'd21:   c = -18'sd7580;
            5'd22:   c = 18'sd7855;
            5'd23:   c = 18'sd41639;
            5'd24:   c = 18'sd27227;
            5'd25:   c = -18'sd5286;
            5'd26:   c = -18'sd2792;
            5'd27:   c = 18'sd3055;
            5'd28:   c = -18'sd780;
            5'd29:   c = -18'sd332;
            5'd30:   c = 18'sd183;
            5'd31:   c = -18'sd3;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Phase of the output after this one
    function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph);
        logic [STEP_W-1:0] s;
        s = STEP_W'(ph) + STEP_W'(DOWN_FACTOR);
        return PHASE_W'(s % STEP_W'(UP_FACTOR));
    endfunction

    // Inputs to skip before the output after this one
    function automatic logic [WAIT_W-1:0] next_wait(input logic [PHASE_W-1:0] ph);
        logic [STEP_W-1:0] s;
        logic [STEP_W-1:0] adv;
        s   = STEP_W'(ph) + STEP_W'(DOWN_FACTOR);
        adv = s / STEP_W'(UP_FACTOR);
        return (adv != '0) ? WAIT_W'(adv - STEP_W'(1)) : '0;
    endfunction

endpackage

// ----- design/pr23_mac.sv -----
// ----------------------------------------------------------------------------
// pr23_mac - shared multiply-accumulate unit
// One 18x16 signed multiply per cycle into a product register, then a wide
// accumulate on the following cycle.
// ----------------------------------------------------------------------------
module pr23_mac (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  pr23_pkg::mac_ctrl_t                     ctrl,
    input  logic signed [pr23_pkg::COEF_WIDTH-1:0]  coef,
    input  logic signed [pr23_pkg::SAMPLE_W-1:0]    sample,
    output logic signed [pr23_pkg::ACC_W-1:0]       acc,
    output logic                                    busy
);

    logic signed [pr23_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                               prod_vld_reg, prod_vld_next;
    logic signed [pr23_pkg::ACC_W-1:0]  acc_reg, acc_next;

    // multiply stage
    always_comb begin
        prod_next     = coef * sample;
        prod_vld_next = ctrl.issue;
    end

    // accumulate stage
    always_comb begin
        if (ctrl.start) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + pr23_pkg::ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= prod_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule

// ----- design/polyphase_resampler_up2_down3_core.sv -----
// ----------------------------------------------------------------------------
// polyphase_resampler_up2_down3_core - 2/3 rational polyphase resampler
// Result path: an output-producing input runs the sixteen-tap loop on the
//   shared MAC, a drain state, then truncate/saturate in the output state.
// Input: a skipped input is taken at one per cycle; an output-producing
//   input holds s_tready low until the output register takes its result.
// Reset: synchronous active-low aresetn clears the delay line, phase, skip
//   count and handshake state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module polyphase_resampler_up2_down3_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] in_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [15:0] out_sample
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [pr23_pkg::TAP_W-1:0] TAP_LAST =
        pr23_pkg::TAP_W'(pr23_pkg::TAPS_PER_PHASE - 1);

    logic [1:0]                            state_reg, state_next;
    logic [pr23_pkg::TAP_W-1:0]            tap_reg, tap_next;
    logic [pr23_pkg::TAP_W-1:0]            wpos_reg, wpos_next;
    logic [pr23_pkg::PHASE_W-1:0]          phase_reg, phase_next;
    logic [pr23_pkg::WAIT_W-1:0]           wait_reg, wait_next;
    logic signed [pr23_pkg::SAMPLE_W-1:0]  dline_reg [pr23_pkg::TAPS_PER_PHASE];
    logic                                  out_vld_reg, out_vld_next;
    logic [15:0]                           out_data_reg, out_data_next;

    logic                                  s_xfer;
    logic                                  out_free;
    logic [pr23_pkg::TAP_W-1:0]            rd_idx;
    pr23_pkg::mac_ctrl_t                   mac_ctrl;
    logic signed [pr23_pkg::COEF_WIDTH-1:0] mac_coef;
    logic signed [pr23_pkg::SAMPLE_W-1:0]  mac_sample;
    logic signed [pr23_pkg::ACC_W-1:0]     mac_acc;
    logic                                  mac_busy;
    logic signed [pr23_pkg::ACC_W-1:0]     acc_adj;
    logic signed [pr23_pkg::ACC_W-1:0]     quot;
    logic signed [pr23_pkg::ACC_W-1:0]     sat;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    // tap fetch: newest sample first
    assign rd_idx     = wpos_reg - pr23_pkg::TAP_W'(1) - tap_reg;
    assign mac_sample = dline_reg[rd_idx];
    assign mac_coef   = pr23_pkg::coef_rom({phase_reg, tap_reg});

    pr23_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .sample  (mac_sample),
        .acc     (mac_acc),
        .busy    (mac_busy)
    );

    // truncate toward zero, then saturate to int16
    always_comb begin
        acc_adj = mac_acc;
        if (mac_acc[pr23_pkg::ACC_W-1]) begin
            acc_adj = mac_acc + pr23_pkg::ACC_W'((1 << pr23_pkg::COEF_FRAC) - 1);
        end
        quot = acc_adj >>> pr23_pkg::COEF_FRAC;
        if (quot > pr23_pkg::SAT_MAX) begin
            sat = pr23_pkg::SAT_MAX;
        end else if (quot < pr23_pkg::SAT_MIN) begin
            sat = pr23_pkg::SAT_MIN;
        end else begin
            sat = quot;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        tap_next      = tap_reg;
        wpos_next     = wpos_reg;
        phase_next    = phase_reg;
        wait_next     = wait_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        mac_ctrl      = '0;

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    wpos_next = wpos_reg + pr23_pkg::TAP_W'(1);
                    if (wait_reg != '0) begin
                        wait_next = wait_reg - pr23_pkg::WAIT_W'(1);
                    end else begin
                        mac_ctrl.start = 1'b1;
                        tap_next       = '0;
                        state_next     = S_MAC;
                    end
                end
            end
            S_MAC: begin
                mac_ctrl.issue = 1'b1;
                tap_next       = tap_reg + pr23_pkg::TAP_W'(1);
                if (tap_reg == TAP_LAST) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_data_next = sat[15:0];
                    wait_next     = pr23_pkg::next_wait(phase_reg);
                    phase_next    = pr23_pkg::next_phase(phase_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tap_reg     <= '0;
            wpos_reg    <= '0;
            phase_reg   <= '0;
            wait_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            wpos_reg    <= wpos_next;
            phase_reg   <= phase_next;
            wait_reg    <= wait_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // delay line, zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pr23_pkg::TAPS_PER_PHASE; i++) begin
                dline_reg[i] <= '0;
            end
        end else if (s_xfer) begin
            dline_reg[wpos_reg] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // a skipped input only counts down the skip register
    a_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && wait_reg != '0) |=>
            (state_reg == S_IDLE && wait_reg == $past(wait_reg) - pr23_pkg::WAIT_W'(1)))
        else $error("skip count not decremented");

    // every transfer advances the write slot by one
    a_wpos: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (wpos_reg == $past(wpos_reg) + pr23_pkg::TAP_W'(1)))
        else $error("write slot did not advance");

    // the final tap leads to the drain cycle
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC && tap_reg == TAP_LAST) |=> (state_reg == S_LAST))
        else $error("tap loop did not end at the last tap");

    // the accumulator is settled before truncation
    a_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> !mac_busy)
        else $error("MAC still accumulating at output");

    // a new result only appears from the output state
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result loaded outside output state");

endmodule

// ----- bench/tb_polyphase_resampler_up2_down3_core.sv -----
// ----------------------------------------------------------------------------
// tb_polyphase_resampler_up2_down3_core - self-checking bench for the resampler
// Streams signed audio samples into the core and compares every output
// transfer against an in-bench model of the 2/3 polyphase filter: delay line,
// phase and skip count, Q2.16 dot product, truncation and saturation. A short
// directed table (warm-up, rails, both saturation directions) is followed by
// bursts of random audio with random gaps on the input and stalls on the
// output.
// ----------------------------------------------------------------------------
module tb_polyphase_resampler_up2_down3_core;

    localparam int ROM_DEPTH      = pr23_pkg::UP_FACTOR * pr23_pkg::TAPS_PER_PHASE;
    localparam int RESULT_LATENCY = 19;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ITEMS   = 626;
    localparam int DIR_ROWS       = 24;

    // Prototype filter, split by phase: entry phase*TAPS_PER_PHASE + tap
    localparam logic signed [pr23_pkg::COEF_WIDTH-1:0] PHASE_COEF [ROM_DEPTH] = '{
        -18'sd3,     18'sd183,   -18'sd332,  -18'sd780,
        18'sd3055,   -18'sd2792, -18'sd5286, 18'sd27227,
        18'sd41639,  18'sd7855,  -18'sd7580, 18'sd2071,
        18'sd1107,   -18'sd1051, 18'sd189,   18'sd31,
        18'sd31,     18'sd189,   -18'sd1051, 18'sd1107,
        18'sd2071,   -18'sd7580, 18'sd7855,  18'sd41639,
        18'sd27227,  -18'sd5286, -18'sd2792, 18'sd3055,
        -18'sd780,   -18'sd332,  18'sd183,   -18'sd3
    };

    // Directed rows; 'known' marks an output value that is fixed by hand
    typedef struct packed {
        logic signed [pr23_pkg::SAMPLE_W-1:0] sample;
        logic                                 known;
        logic signed [pr23_pkg::SAMPLE_W-1:0] want;
    } dir_row_t;

    // Taps 7 and 8 of phase 0 alone exceed unity gain, so a rail pair sitting
    // there drives the output into saturation
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{16'sh0000, 1'b1, 16'sh0000},   // first output after reset is silent
        '{16'sh7FFF, 1'b0, 16'sh0000},
        '{16'sh7FFF, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b1, 16'sh7FFF},   // positive rail pair on taps 7/8
        '{16'sh8000, 1'b0, 16'sh0000},
        '{16'sh8000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b0, 16'sh0000},
        '{16'sh0000, 1'b1, 16'sh8000},   // negative rail pair on taps 7/8
        '{16'sh5555, 1'b0, 16'sh0000},
        '{16'shAAAA, 1'b0, 16'sh0000},
        '{16'sh0001, 1'b0, 16'sh0000},
        '{16'shFFFF, 1'b0, 16'sh0000},
        '{16'sh7FFF, 1'b0, 16'sh0000}
    };

    // Character of a random burst of audio
    typedef enum logic [2:0] {
        AUDIO_NOISE,
        AUDIO_FULL_SCALE,
        AUDIO_DC,
        AUDIO_QUIET,
        AUDIO_NEAR_RAIL
    } audio_kind_e;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [15:0] in_sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] out_sample

    // Filter model state
    logic signed [pr23_pkg::SAMPLE_W-1:0] hist [pr23_pkg::TAPS_PER_PHASE];
    logic [pr23_pkg::TAP_W-1:0]           hist_wr;
    logic [pr23_pkg::PHASE_W-1:0]         out_phase;
    logic [pr23_pkg::WAIT_W-1:0]          skip_left;

    logic signed [pr23_pkg::SAMPLE_W-1:0] pending_out [$];
    int                                   error_count = 0;
    int                                   cycle_count = 0;
    bit                                   drain_on    = 1'b0;

    polyphase_resampler_up2_down3_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d outputs outstanding",
                     cycle_count, pending_out.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 45);
    endfunction

    task automatic clear_history();
        for (int i = 0; i < pr23_pkg::TAPS_PER_PHASE; i++) hist[i] = '0;
        hist_wr   = '0;
        out_phase = '0;
        skip_left = '0;
    endtask

    // Store one sample; on an output slot form the phase dot product,
    // truncate toward zero and clamp to 16 bits
    task automatic resample_step(input logic signed [pr23_pkg::SAMPLE_W-1:0] smp,
                                 output bit emits,
                                 output logic signed [pr23_pkg::SAMPLE_W-1:0] y);
        longint                     acc;
        longint                     q;
        int                         adv;
        logic [pr23_pkg::TAP_W-1:0] idx;
        hist[hist_wr] = smp;
        hist_wr       = hist_wr + 1'b1;
        emits         = 1'b0;
        y             = '0;
        if (skip_left != 0) begin
            skip_left = skip_left - 1'b1;
        end else begin
            acc = 0;
            for (int t = 0; t < pr23_pkg::TAPS_PER_PHASE; t++) begin
                // newest sample meets tap 0
                idx = hist_wr - pr23_pkg::TAP_W'(1) - pr23_pkg::TAP_W'(t);
                acc += longint'(PHASE_COEF[int'(out_phase) * pr23_pkg::TAPS_PER_PHASE + t])
                     * longint'(hist[idx]);
            end
            q = acc / (longint'(1) << pr23_pkg::COEF_FRAC);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            y     = pr23_pkg::SAMPLE_W'(q);
            emits = 1'b1;
            adv       = (int'(out_phase) + pr23_pkg::DOWN_FACTOR) / pr23_pkg::UP_FACTOR;
            skip_left = (adv > 0) ? pr23_pkg::WAIT_W'(adv - 1) : '0;
            out_phase = pr23_pkg::PHASE_W'((int'(out_phase) + pr23_pkg::DOWN_FACTOR)
                                           % pr23_pkg::UP_FACTOR);
        end
    endtask

    // Entered and left at a falling edge; the model runs on the transfer
    task automatic send_sample(input logic signed [pr23_pkg::SAMPLE_W-1:0] smp,
                               input int gap, input logic known,
                               input logic signed [pr23_pkg::SAMPLE_W-1:0] want);
        bit                                   emits;
        logic signed [pr23_pkg::SAMPLE_W-1:0] y;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        resample_step(smp, emits, y);
        if (emits) pending_out.push_back(known ? want : y);
        @(negedge aclk);
    endtask

    function automatic logic signed [pr23_pkg::SAMPLE_W-1:0] audio_sample(
        input audio_kind_e kind, input logic signed [pr23_pkg::SAMPLE_W-1:0] level
    );
        case (kind)
            AUDIO_FULL_SCALE: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            AUDIO_DC:         return level;
            AUDIO_QUIET:      return pr23_pkg::SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            AUDIO_NEAR_RAIL:  return $urandom_range(0, 1)
                                  ? pr23_pkg::SAMPLE_W'(32767 - int'($urandom_range(0, 15)))
                                  : pr23_pkg::SAMPLE_W'(-32768 + int'($urandom_range(0, 15)));
            default:          return pr23_pkg::SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Output side: ready runs broken by stalls, occasionally a long clean run
    initial begin
        int ready_left;
        int stall_left;
        ready_left = 0;
        stall_left = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (ready_left == 0 && stall_left == 0) begin
                ready_left = ($urandom_range(0, 15) == 0) ? 300 : $urandom_range(1, 24);
                stall_left = pick_idle();
            end
            if (drain_on || ready_left > 0) begin
                m_tready <= 1'b1;
                if (ready_left > 0) ready_left--;
            end else begin
                m_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Output checker
    always @(posedge aclk) begin : out_check
        logic signed [pr23_pkg::SAMPLE_W-1:0] exp_s;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                report_error($sformatf("unexpected output transfer, out_sample %0d",
                                       $signed(m_tdata)));
            end else begin
                exp_s = pending_out.pop_front();
                if (m_tdata !== exp_s)
                    report_error($sformatf("out_sample got %0d expected %0d",
                                           $signed(m_tdata), exp_s));
            end
        end
    end

    // Stimulus
    initial begin
        audio_kind_e                          kind;
        logic signed [pr23_pkg::SAMPLE_W-1:0] level;
        int                                   burst_len;
        int                                   sent;
        bit                                   gaps_on;

        clear_history();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_sample(DIR_TABLE[r].sample, pick_idle(), DIR_TABLE[r].known,
                        DIR_TABLE[r].want);

        // Random bursts of audio
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind      = audio_kind_e'($urandom_range(0, 4));
            level     = pr23_pkg::SAMPLE_W'($urandom);
            burst_len = $urandom_range(8, 40);
            gaps_on   = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < burst_len; i++)
                send_sample(audio_sample(kind, level), gaps_on ? pick_idle() : 0,
                            1'b0, '0);
            sent += burst_len;
        end
        s_tvalid <= 1'b0;

        // Drain, then watch for stray outputs
        drain_on = 1'b1;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (2 * RESULT_LATENCY) @(posedge aclk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
design/pr23_pkg.sv
design/pr23_mac.sv
design/polyphase_resampler_up2_down3_core.sv
bench/tb_polyphase_resampler_up2_down3_core.sv
